FILE: design/i2c_master_bit_sequencer_assert.svh
// Assertion macros for the I2C bit sequencer, used by i2cbs_seq.
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define I2CBS_ASSERT_NOW(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("i2c sequencer: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define I2CBS_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("i2c sequencer: next-cycle check failed");

`endif

FILE: design/i2cbs_pkg.sv
// Types, codes and pin-phase tables of the I2C master bit sequencer.
package i2cbs_pkg;

	localparam int PT_WIDTH = 16;
	localparam logic [PT_WIDTH-1:0] PHASE_TICKS_RESET = 16'd100;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Item kinds on the command channel
	localparam logic [3:0] KIND_TICK  = 4'd0;
	localparam logic [3:0] KIND_START = 4'd1;
	localparam logic [3:0] KIND_STOP  = 4'd2;
	localparam logic [3:0] KIND_WRITE = 4'd3;
	localparam logic [3:0] KIND_READ  = 4'd4;
	localparam logic [3:0] KIND_ACK   = 4'd5;
	localparam logic [3:0] KIND_NACK  = 4'd6;
	localparam logic [3:0] KIND_WAIT  = 4'd7;
	localparam logic [3:0] KIND_PROBE = 4'd8;

	// Last phase indices and probe sub-sequence offsets
	localparam logic [5:0] START_LAST       = 6'd2;
	localparam logic [5:0] WRITE_LAST       = 6'd23;
	localparam logic [5:0] READ_LAST        = 6'd15;
	localparam logic [5:0] ACK_LAST         = 6'd2;
	localparam logic [5:0] PROBE_WRITE_BASE = 6'd3;
	localparam logic [5:0] PROBE_WAIT_BASE  = 6'd27;
	localparam logic [5:0] PROBE_STOP_IDX   = 6'd30;

	// Running command, one-hot
	typedef enum logic [8:0] {
		CMD_IDLE  = 9'b000000001,
		CMD_START = 9'b000000010,
		CMD_STOP  = 9'b000000100,
		CMD_WRITE = 9'b000001000,
		CMD_READ  = 9'b000010000,
		CMD_ACK   = 9'b000100000,
		CMD_NACK  = 9'b001000000,
		CMD_WAIT  = 9'b010000000,
		CMD_PROBE = 9'b100000000
	} cmd_state_t;

	// Action taken when a phase ends
	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_ACK  = 2'd1,
		ACT_BIT  = 2'd2
	} act_t;

	typedef struct packed {
		logic ok;
		logic scl_keep;
		logic scl;
		logic sda;
		act_t act;
	} phase_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] tx_byte;
		logic       sda_in;
		logic       scl_in;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_fail;
		logic       rejected;
	} res_item_t;

	function automatic cmd_state_t kind_to_cmd(logic [3:0] kind);
		cmd_state_t c;
		unique case (kind)
			KIND_TICK:  c = CMD_IDLE;
			KIND_START: c = CMD_START;
			KIND_STOP:  c = CMD_STOP;
			KIND_WRITE: c = CMD_WRITE;
			KIND_READ:  c = CMD_READ;
			KIND_ACK:   c = CMD_ACK;
			KIND_NACK:  c = CMD_NACK;
			KIND_WAIT:  c = CMD_WAIT;
			KIND_PROBE: c = CMD_PROBE;
			default:    c = CMD_IDLE;
		endcase
		return c;
	endfunction

	function automatic phase_t no_phase();
		phase_t ph;
		ph = '{ok: 1'b0, scl_keep: 1'b0, scl: 1'b0, sda: 1'b0, act: ACT_NONE};
		return ph;
	endfunction

	function automatic phase_t start_phase(logic [5:0] idx);
		phase_t ph;
		ph = no_phase();
		ph.ok  = (idx <= START_LAST);
		ph.scl = (idx < START_LAST);
		ph.sda = (idx == '0);
		return ph;
	endfunction

	function automatic phase_t stop_phase(logic [5:0] idx);
		phase_t ph;
		ph = no_phase();
		ph.ok  = (idx == '0);
		ph.scl = 1'b1;
		ph.sda = 1'b0;
		return ph;
	endfunction

	// Three phases per bit: bit number is idx/3 (small compare table), SCL high on the middle one
	function automatic phase_t write_phase(logic [5:0] idx, logic [7:0] sr);
		phase_t ph;
		logic [2:0] q;
		logic [5:0] r;
		ph = no_phase();
		q = '0;
		for (int i = 0; i < 8; i++) begin
			if (idx >= 6'(3 * i)) q = 3'(i);
		end
		r = idx - 6'(3 * int'(q));
		ph.ok  = (idx <= WRITE_LAST);
		ph.scl = (r == 6'd1);
		ph.sda = sr[~q];
		return ph;
	endfunction

	function automatic phase_t read_phase(logic [5:0] idx);
		phase_t ph;
		ph = no_phase();
		ph.ok  = (idx <= READ_LAST);
		ph.scl = ~idx[0];
		ph.sda = 1'b1;
		ph.act = idx[0] ? ACT_NONE : ACT_BIT;
		return ph;
	endfunction

	// ack, nack and wait_ack share one shape
	function automatic phase_t ack_phase(cmd_state_t cmd, logic [5:0] idx);
		phase_t ph;
		ph = no_phase();
		ph.ok       = (idx <= ACK_LAST);
		ph.scl_keep = (idx == 6'd0);
		ph.scl      = (idx == 6'd1);
		ph.sda      = (cmd != CMD_ACK);
		ph.act      = (cmd == CMD_WAIT && idx == 6'd1) ? ACT_ACK : ACT_NONE;
		return ph;
	endfunction

	function automatic phase_t phase_of(cmd_state_t cmd, logic [5:0] idx, logic [7:0] sr);
		phase_t ph;
		ph = no_phase();
		unique case (cmd)
			CMD_START: ph = start_phase(idx);
			CMD_STOP:  ph = stop_phase(idx);
			CMD_WRITE: ph = write_phase(idx, sr);
			CMD_READ:  ph = read_phase(idx);
			CMD_ACK, CMD_NACK, CMD_WAIT: ph = ack_phase(cmd, idx);
			CMD_PROBE: begin
				if (idx < PROBE_WRITE_BASE) ph = start_phase(idx);
				else if (idx < PROBE_WAIT_BASE) ph = write_phase(idx - PROBE_WRITE_BASE, sr);
				else if (idx < PROBE_STOP_IDX) ph = ack_phase(CMD_WAIT, idx - PROBE_WAIT_BASE);
				else if (idx == PROBE_STOP_IDX) ph = stop_phase('0);
				else ph = no_phase();
			end
			default: ph = no_phase();
		endcase
		return ph;
	endfunction

endpackage

FILE: design/i2cbs_in_reg.sv
// Input register stage of the I2C bit sequencer command channel.
module i2cbs_in_reg
	import i2cbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd,
	input  logic      advance,
	output logic      valid_s1,
	output cmd_item_t item_s1
);

	logic load;

	// Hold the stage only while it is full and downstream is blocked
	assign cmd_stall = valid_s1 && !advance;
	assign load = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= cmd_valid;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (load && cmd_valid) begin
			item_s1 <= cmd;
		end
	end

endmodule

FILE: design/i2cbs_seq.sv
// Pin-phase sequencer: command state, tick counter, shift register and result logic.
`include "i2c_master_bit_sequencer_assert.svh"

module i2cbs_seq
	import i2cbs_pkg::*;
#(
	parameter int TICK_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [PT_WIDTH-1:0] cfg_wdata,
	input  logic                fire,
	input  cmd_item_t           item_s1,
	output res_item_t           res_d
);

	localparam int CW = ((TICK_WIDTH > PT_WIDTH) ? TICK_WIDTH : PT_WIDTH) + 1;
	localparam logic [CW-1:0] TICK_LIMIT = CW'(1) << TICK_WIDTH;

	logic [PT_WIDTH-1:0]   phase_ticks_q;
	cmd_state_t            active_q, active_d;
	logic [5:0]            idx_q, idx_d;
	logic [TICK_WIDTH-1:0] tick_q, tick_d;
	logic [7:0]            sr_q, sr_d;
	logic [3:0]            bit_cnt_q, bit_cnt_d;
	logic                  scl_q, scl_d;
	logic                  sda_q, sda_d;
	logic [7:0]            rx_q, rx_d;
	logic                  ack_q, ack_d;
	logic                  done_d, rej_d;

	cmd_state_t  start_cmd;
	logic        is_cmd;
	logic [7:0]  start_sr;
	phase_t      start_ph, cur_ph, nxt_ph;
	logic [CW-1:0] tick_inc, pt_ext, eff_ticks;
	logic        phase_end;
	logic [7:0]  sr_after;
	logic [5:0]  idx_inc;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RESET;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	// Phase length: zero acts as one, clamp to the counter range
	assign pt_ext    = CW'(phase_ticks_q);
	assign eff_ticks = (pt_ext > TICK_LIMIT) ? TICK_LIMIT : pt_ext;
	assign tick_inc  = CW'(tick_q) + CW'(1);
	assign phase_end = (tick_inc >= eff_ticks);

	// Command decode and first phase
	assign start_cmd = kind_to_cmd(item_s1.kind);
	assign is_cmd    = (start_cmd != CMD_IDLE);
	assign start_sr  = (start_cmd == CMD_WRITE || start_cmd == CMD_PROBE) ? item_s1.tx_byte : '0;
	assign start_ph  = phase_of(start_cmd, '0, start_sr);

	// Current and following phase of the running command
	assign cur_ph   = phase_of(active_q, idx_q, sr_q);
	assign sr_after = (cur_ph.act == ACT_BIT) ? {sr_q[6:0], item_s1.sda_in} : sr_q;
	assign idx_inc  = idx_q + 6'd1;
	assign nxt_ph   = phase_of(active_q, idx_inc, sr_after);

	// Next state for the item in the input stage
	always_comb begin
		active_d  = active_q;
		idx_d     = idx_q;
		tick_d    = tick_q;
		sr_d      = sr_q;
		bit_cnt_d = bit_cnt_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		rx_d      = rx_q;
		ack_d     = ack_q;
		done_d    = 1'b0;
		rej_d     = 1'b0;
		if (active_q == CMD_IDLE) begin
			if (is_cmd) begin
				if (start_cmd == CMD_PROBE && !(item_s1.sda_in && item_s1.scl_in)) begin
					// bus not idle: fault reported at once, pins untouched
					ack_d  = 1'b1;
					done_d = 1'b1;
				end else begin
					active_d  = start_cmd;
					idx_d     = '0;
					tick_d    = '0;
					bit_cnt_d = '0;
					sr_d      = start_sr;
					if (!start_ph.scl_keep) scl_d = start_ph.scl;
					sda_d = start_ph.sda;
				end
			end
		end else begin
			rej_d = is_cmd;
			if (phase_end) begin
				if (cur_ph.act == ACT_ACK) ack_d = item_s1.sda_in;
				if (cur_ph.act == ACT_BIT) bit_cnt_d = bit_cnt_q + 4'd1;
				sr_d   = sr_after;
				tick_d = '0;
				idx_d  = idx_inc;
				if (nxt_ph.ok) begin
					if (!nxt_ph.scl_keep) scl_d = nxt_ph.scl;
					sda_d = nxt_ph.sda;
				end else begin
					// last phase done: release SDA after stop, write, ack and probe
					if (active_q == CMD_STOP || active_q == CMD_WRITE ||
						active_q == CMD_ACK || active_q == CMD_PROBE) begin
						sda_d = 1'b1;
					end
					if (active_q == CMD_READ) rx_d = sr_after;
					active_d = CMD_IDLE;
					idx_d    = '0;
					done_d   = 1'b1;
				end
			end else begin
				tick_d = tick_q + TICK_WIDTH'(1);
			end
		end
	end

	// State registers, advanced once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= CMD_IDLE;
			idx_q     <= '0;
			tick_q    <= '0;
			sr_q      <= '0;
			bit_cnt_q <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			rx_q      <= '0;
			ack_q     <= 1'b0;
		end else if (fire) begin
			active_q  <= active_d;
			idx_q     <= idx_d;
			tick_q    <= tick_d;
			sr_q      <= sr_d;
			bit_cnt_q <= bit_cnt_d;
			scl_q     <= scl_d;
			sda_q     <= sda_d;
			rx_q      <= rx_d;
			ack_q     <= ack_d;
		end
	end

	// Result of this item
	always_comb begin
		res_d.scl_out  = scl_d;
		res_d.sda_out  = sda_d;
		res_d.busy_res = (active_d != CMD_IDLE);
		res_d.done_res = done_d;
		res_d.rx_byte  = rx_d;
		res_d.ack_fail = ack_d;
		res_d.rejected = rej_d;
	end

	`I2CBS_ASSERT_NEXT(a_done_goes_idle, fire && done_d, active_q == CMD_IDLE)
	`I2CBS_ASSERT_NOW(a_reject_only_busy, fire && rej_d, active_q != CMD_IDLE)
	`I2CBS_ASSERT_NOW(a_idle_counters_clear, active_q == CMD_IDLE, idx_q == '0 && tick_q == '0)
	`I2CBS_ASSERT_NOW(a_bit_count_range, 1'b1, bit_cnt_q <= BITS_PER_BYTE)

endmodule

FILE: design/i2cbs_out_reg.sv
// Result register of the I2C bit sequencer with its valid/stall handshake.
module i2cbs_out_reg
	import i2cbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  res_item_t res_d,
	output logic      advance,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res
);

	// Register can take a new result when empty or being drained
	assign advance = !res_valid || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= load;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (advance && load) begin
			res <= res_d;
		end
	end

endmodule

FILE: design/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: open-drain SCL/SDA phase sequencer, top level.
//
// Usage: each transaction on the cmd channel (cmd_valid/cmd_stall) carries one item,
// either a tick or a command (start, stop, write, read, ack, nack, wait_ack, probe),
// plus the sampled SDA/SCL levels. Every item yields exactly one transaction on the
// res channel (res_valid/res_stall) with the pin drives, busy, done, rx byte,
// ack_fail and rejected flags. cfg_we/cfg_wdata write phase_ticks, the number of
// items each pin phase is held; write it only while the block is idle.
// The input stage registers each accepted item and the result register its result;
// res_stall can hold the item in the input stage before its result is loaded.
// Throughput: one item per cycle while res_stall is low; each item is one pass
// through phase decoder and tick compare between input stage and result register.
// Reset (arst_n low): idle, both pins released, phase_ticks = 100, flags cleared.
// When res_stall is high the result is held and the input stage fills, after
// which cmd_stall rises; no item is lost or repeated.
module i2c_master_bit_sequencer
	import i2cbs_pkg::*;
#(
	parameter int TICK_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [PT_WIDTH-1:0] cfg_wdata,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  cmd_item_t           cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output res_item_t           res
);

	logic      advance;
	logic      valid_s1;
	logic      fire;
	cmd_item_t item_s1;
	res_item_t res_d;

	assign fire = valid_s1 && advance;

	// Input stage
	i2cbs_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	// Sequencer
	i2cbs_seq #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item_s1   (item_s1),
		.res_d     (res_d)
	);

	// Result register
	i2cbs_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.res_d     (res_d),
		.advance   (advance),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
